// ===== rtl/core/fpalu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpalu_pkg
// shared operation codes, widths and defaults of the fixed-point alu
// ----------------------------------------------------------------------------
package fpalu_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned FUNC_W    = 4;
    localparam int unsigned FRAC_W_DF = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD = 4'd0,
        FN_SUB = 4'd1,
        FN_MUL = 4'd2,
        FN_DIV = 4'd3,
        FN_GT  = 4'd4,
        FN_LT  = 4'd5,
        FN_GE  = 4'd6,
        FN_LE  = 4'd7,
        FN_EQ  = 4'd8,
        FN_NE  = 4'd9,
        FN_MIN = 4'd10,
        FN_MAX = 4'd11,
        FN_INC = 4'd12,
        FN_DEC = 4'd13
    } t_func;

endpackage
`default_nettype wire

// ===== rtl/core/fpalu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpalu_if
// valid/ready channels for the operation and result words
// ----------------------------------------------------------------------------
interface fpalu_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [fpalu_pkg::FUNC_W-1:0]              func;
    logic signed [fpalu_pkg::DATA_W-1:0]       operand_a;
    logic signed [fpalu_pkg::DATA_W-1:0]       operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpalu_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [fpalu_pkg::DATA_W-1:0]       value_out;
    logic                                      compare_true;
    logic                                      divide_by_zero;
    logic                                      saturated;

    modport source (output valid, value_out, compare_true, divide_by_zero, saturated,
                    input ready);
    modport sink   (input valid, value_out, compare_true, divide_by_zero, saturated,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fixed_point_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu
// pipelined add/sub/mul/div/compare/min/max/inc/dec unit for signed raw fixed-point words
// ----------------------------------------------------------------------------
// One operation word enters per cycle and one result word leaves per cycle.
// The pipeline consists of an input register, one compute stage that
// handles add, sub, compares, min, max, inc, dec and the 32x32 magnitude
// product, 32 + FRAC_W restoring-division stages (one quotient bit each),
// and an output stage that rounds half away from zero and saturates product
// and quotient. The whole pipeline advances together; it holds only while a
// finished word sits in the output register and the sink is not ready.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int unsigned FRAC_W = fpalu_pkg::FRAC_W_DF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fpalu_in_if.sink    i_in,
    fpalu_out_if.source o_out
);

    localparam int unsigned DW = fpalu_pkg::DATA_W;
    localparam int unsigned NW = DW + FRAC_W;      // numerator / quotient width
    localparam int unsigned PW = 2 * DW;           // product width

    // global advance
    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    // no word is taken while reset is held
    assign i_in.ready = w_en && i_rst_n;

    // input register
    logic                   r_iv;
    logic [3:0]             r_ifunc;
    logic signed [DW-1:0]   r_ia;
    logic signed [DW-1:0]   r_ib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (w_en) begin
            r_iv <= i_in.valid;
        end
        if (w_en) begin
            r_ifunc <= i_in.func;
            r_ia    <= i_in.operand_a;
            r_ib    <= i_in.operand_b;
        end
    end

    // pipeline stages 0..NW
    logic            r_v    [0:NW];
    logic [3:0]      r_func [0:NW];
    logic [DW-1:0]   r_val  [0:NW];
    logic            r_cmp  [0:NW];
    logic            r_dz   [0:NW];
    logic            r_neg  [0:NW];
    logic [DW-1:0]   r_den  [0:NW];
    logic [NW-1:0]   r_num  [0:NW];
    logic [DW-1:0]   r_rem  [0:NW];
    logic [NW-1:0]   r_q    [0:NW];
    logic [PW-1:0]   r_prod [0:NW];

    // compute stage
    logic [DW-1:0] w_mag_a;
    logic [DW-1:0] w_mag_b;
    logic [DW-1:0] n_val;
    logic          n_cmp;

    assign w_mag_a = r_ia[DW-1] ? (~r_ia + 1'b1) : r_ia;
    assign w_mag_b = r_ib[DW-1] ? (~r_ib + 1'b1) : r_ib;

    always_comb begin
        n_val = '0;
        n_cmp = 1'b0;
        case (fpalu_pkg::t_func'(r_ifunc))
            fpalu_pkg::FN_ADD: n_val = r_ia + r_ib;
            fpalu_pkg::FN_SUB: n_val = r_ia - r_ib;
            fpalu_pkg::FN_GT:  n_cmp = (r_ia > r_ib);
            fpalu_pkg::FN_LT:  n_cmp = (r_ia < r_ib);
            fpalu_pkg::FN_GE:  n_cmp = (r_ia >= r_ib);
            fpalu_pkg::FN_LE:  n_cmp = (r_ia <= r_ib);
            fpalu_pkg::FN_EQ:  n_cmp = (r_ia == r_ib);
            fpalu_pkg::FN_NE:  n_cmp = (r_ia != r_ib);
            fpalu_pkg::FN_MIN: n_val = (r_ia < r_ib) ? r_ia : r_ib;
            fpalu_pkg::FN_MAX: n_val = (r_ia > r_ib) ? r_ia : r_ib;
            fpalu_pkg::FN_INC: n_val = r_ia + 1'b1;
            fpalu_pkg::FN_DEC: n_val = r_ia - 1'b1;
            default:           n_val = '0;   // mul, div resolved later; unused codes
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= r_iv;
        end
        if (w_en) begin
            r_func[0] <= r_ifunc;
            r_val[0]  <= n_val;
            r_cmp[0]  <= n_cmp;
            r_dz[0]   <= (r_ifunc == fpalu_pkg::FN_DIV) && (r_ib == '0);
            r_neg[0]  <= r_ia[DW-1] ^ r_ib[DW-1];
            r_den[0]  <= w_mag_b;
            r_num[0]  <= {w_mag_a, {FRAC_W{1'b0}}};
            r_rem[0]  <= '0;
            r_q[0]    <= '0;
            r_prod[0] <= w_mag_a * w_mag_b;
        end
    end

    // restoring division, one quotient bit per stage
    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_div
            logic [DW:0] w_trial;
            logic        w_ge;
            logic [DW:0] w_diff;

            assign w_trial = {r_rem[k], r_num[k][NW-1-k]};
            assign w_ge    = (w_trial >= {1'b0, r_den[k]});
            assign w_diff  = w_trial - {1'b0, r_den[k]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (w_en) begin
                    r_v[k+1] <= r_v[k];
                end
                if (w_en) begin
                    r_func[k+1] <= r_func[k];
                    r_val[k+1]  <= r_val[k];
                    r_cmp[k+1]  <= r_cmp[k];
                    r_dz[k+1]   <= r_dz[k];
                    r_neg[k+1]  <= r_neg[k];
                    r_den[k+1]  <= r_den[k];
                    r_num[k+1]  <= r_num[k];
                    r_prod[k+1] <= r_prod[k];
                    r_rem[k+1]  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                    r_q[k+1]    <= r_q[k] | (NW'(w_ge) << (NW-1-k));
                end
            end
        end
    endgenerate

    // rounding and saturation
    logic [PW-1:0] w_mul_mag;
    logic [NW:0]   w_div_mag;
    logic          w_div_up;
    logic [PW-1:0] w_mag;
    logic          n_sat;
    logic [DW-1:0] n_res;

    assign w_mul_mag = (r_prod[NW] + (PW'(1) << (FRAC_W - 1))) >> FRAC_W;
    assign w_div_up  = ({r_rem[NW], 1'b0} >= {1'b0, r_den[NW]});
    assign w_div_mag = {1'b0, r_q[NW]} + (NW+1)'(w_div_up);

    always_comb begin
        w_mag = (r_func[NW] == fpalu_pkg::FN_MUL) ? w_mul_mag : PW'(w_div_mag);
        n_sat = 1'b0;
        n_res = r_val[NW];
        if ((r_func[NW] == fpalu_pkg::FN_MUL) ||
            ((r_func[NW] == fpalu_pkg::FN_DIV) && !r_dz[NW])) begin
            if (r_neg[NW]) begin
                if (w_mag > (PW'(1) << (DW-1))) begin
                    n_sat = 1'b1;
                    n_res = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    n_res = ~w_mag[DW-1:0] + 1'b1;
                end
            end else begin
                if (w_mag > PW'({1'b0, {(DW-1){1'b1}}})) begin
                    n_sat = 1'b1;
                    n_res = {1'b0, {(DW-1){1'b1}}};
                end else begin
                    n_res = w_mag[DW-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (w_en) begin
            o_out.valid <= r_v[NW];
        end
        if (w_en) begin
            o_out.value_out      <= n_res;
            o_out.compare_true   <= r_cmp[NW];
            o_out.divide_by_zero <= r_dz[NW];
            o_out.saturated      <= n_sat;
        end
    end

    // checks
    a_dz_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.divide_by_zero && o_out.saturated))
        else $error("divide by zero word also flagged saturated");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divide_by_zero) |-> (o_out.value_out == '0))
        else $error("divide by zero word carries a nonzero value");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input held off without a blocked output word");

endmodule
`default_nettype wire
